FILE: src/npps_pkg.sv
// Shared types and constants for the nonpreemptive priority scheduler.
`timescale 1ns / 1ps

package npps_pkg;

   localparam int MAX_JOBS_DEFAULT = 64;

   localparam int TAG_W   = 8;
   localparam int PRIO_W  = 8;
   localparam int ARR_W   = 16;
   localparam int BURST_W = 16;
   localparam int TIME_W  = 23;
   localparam int SUM_W   = 29;

   // One job table entry; the finished flag lives with the job.
   typedef struct packed {
      logic               finished;
      logic [TAG_W-1:0]   tag;
      logic [PRIO_W-1:0]  prio;
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Outcome of one pass over the job table.
   typedef struct packed {
      logic             any_ready;
      logic             any_pending;
      entry_type        best;
      logic [ARR_W-1:0] next_arrival;
   } pick_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT,
      ST_ZREAD,
      ST_ZCHECK
   } state_type;

endpackage

FILE: src/npps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module npps_ram #(
   parameter int WIDTH = npps_pkg::ENTRY_W,
   parameter int DEPTH = npps_pkg::MAX_JOBS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/npps_select.sv
// Running selection of the best ready job and the earliest future arrival.
`timescale 1ns / 1ps

module npps_select #(
   parameter int MAX_JOBS = npps_pkg::MAX_JOBS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            clear,
   input  logic                            valid,
   input  npps_pkg::entry_type             entry,
   input  logic [$clog2(MAX_JOBS)-1:0]     idx,
   input  logic [npps_pkg::TIME_W-1:0]     now,
   output npps_pkg::pick_type              pick,
   output logic [$clog2(MAX_JOBS)-1:0]     best_idx
);

   localparam int IDX_W = $clog2(MAX_JOBS);

   npps_pkg::pick_type    pick_ff;
   npps_pkg::pick_type    pick_in;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [IDX_W-1:0]      best_idx_in;
   logic                  pending;
   logic                  ready;
   logic                  better;

   always_comb begin
      pending = !entry.finished && (entry.burst != '0);
      ready   = pending &&
                ({{(npps_pkg::TIME_W-npps_pkg::ARR_W){1'b0}}, entry.arrival} <= now);
      // On equal priority the earlier arrival wins; on a full tie the entry scanned first is kept.
      better  = !pick_ff.any_ready ||
                (entry.prio < pick_ff.best.prio) ||
                ((entry.prio == pick_ff.best.prio) &&
                 (entry.arrival < pick_ff.best.arrival));

      pick_in     = pick_ff;
      best_idx_in = best_idx_ff;
      if (clear) begin
         pick_in.any_ready   = 1'b0;
         pick_in.any_pending = 1'b0;
      end else if (valid) begin
         if (ready) begin
            pick_in.any_ready = 1'b1;
            if (better) begin
               pick_in.best = entry;
               best_idx_in  = idx;
            end
         end else if (pending) begin
            if (!pick_ff.any_pending || (entry.arrival < pick_ff.next_arrival)) begin
               pick_in.next_arrival = entry.arrival;
            end
            pick_in.any_pending = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pick_ff     <= pick_in;
      best_idx_ff <= best_idx_in;
   end

   assign pick     = pick_ff;
   assign best_idx = best_idx_ff;

endmodule

FILE: src/nonpreemptive_priority_scheduler.sv
// Top level of the nonpreemptive priority scheduler: sequencer, time and sum registers.
`timescale 1ns / 1ps
//
//   Channel | Direction | Handshake           | Carries
//   req_    | in        | req_valid/req_stall | one job; last_job starts the schedule
//   rsp_    | out       | rsp_valid/rsp_stall | one result per job, in run order
//
// Loading takes one cycle per job. Each scheduling decision is one pass over the
// job table through the single read port, then the DECIDE and EMIT states finish
// and post the result; a time jump to the next arrival costs another pass.
// Jobs with zero burst are reported at the end, from a pass through ZREAD and ZCHECK.
// Reset is synchronous and clears the sequencer, the job count and the output valid.
// req_stall is high from the last job until the closing pass for zero-burst jobs has
// ended, after the final result has been loaded into the output register; a stalled
// result holds the sequencer only when the next result is ready.

module nonpreemptive_priority_scheduler #(
   parameter int MAX_JOBS = npps_pkg::MAX_JOBS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [npps_pkg::TAG_W-1:0]    req_job_tag,
   input  logic [npps_pkg::PRIO_W-1:0]   req_job_priority,
   input  logic [npps_pkg::ARR_W-1:0]    req_arrival_time,
   input  logic [npps_pkg::BURST_W-1:0]  req_burst_time,
   input  logic                          req_last_job,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [npps_pkg::TAG_W-1:0]    rsp_done_tag,
   output logic [npps_pkg::TIME_W-1:0]   rsp_start_time,
   output logic [npps_pkg::TIME_W-1:0]   rsp_wait_time,
   output logic [npps_pkg::TIME_W-1:0]   rsp_turnaround_time,
   output logic [npps_pkg::SUM_W-1:0]    rsp_wait_sum,
   output logic [npps_pkg::SUM_W-1:0]    rsp_turnaround_sum,
   output logic                          rsp_last_result
);

   localparam int IDX_W  = $clog2(MAX_JOBS);
   localparam int CNT_W  = $clog2(MAX_JOBS + 1);
   localparam int TIME_W = npps_pkg::TIME_W;
   localparam int SUM_W  = npps_pkg::SUM_W;

   npps_pkg::state_type   state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]      emitted_ff, emitted_in;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic [TIME_W-1:0]     st_ff, st_in;
   logic [TIME_W-1:0]     wt_ff, wt_in;
   logic [TIME_W-1:0]     tt_ff, tt_in;
   logic [SUM_W-1:0]      wsum_ff, wsum_in;
   logic [SUM_W-1:0]      tsum_ff, tsum_in;
   logic                  chk_valid_ff;
   logic [IDX_W-1:0]      chk_idx_ff;

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   npps_pkg::entry_type   rd_data;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   npps_pkg::entry_type   wr_data;

   logic                  sel_clear;
   npps_pkg::pick_type    pick;
   logic [IDX_W-1:0]      best_idx;

   logic                  emit;
   logic                  emit_zero;
   logic                  out_hold;
   logic                  last_c;
   logic                  stall_c;

   logic                          rsp_valid_ff;
   logic [npps_pkg::TAG_W-1:0]    rsp_tag_ff;
   logic [TIME_W-1:0]             rsp_start_ff;
   logic [TIME_W-1:0]             rsp_wait_ff;
   logic [TIME_W-1:0]             rsp_turn_ff;
   logic [SUM_W-1:0]              rsp_wsum_ff;
   logic [SUM_W-1:0]              rsp_tsum_ff;
   logic                          rsp_last_ff;

   npps_ram #(
      .WIDTH (npps_pkg::ENTRY_W),
      .DEPTH (MAX_JOBS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   npps_select #(
      .MAX_JOBS (MAX_JOBS)
   ) u_select (
      .clock    (clock),
      .clear    (sel_clear),
      .valid    (chk_valid_ff),
      .entry    (rd_data),
      .idx      (chk_idx_ff),
      .now      (time_ff),
      .pick     (pick),
      .best_idx (best_idx)
   );

   // A new result may be loaded unless the current one is still being refused.
   assign out_hold = rsp_valid_ff && rsp_stall;
   assign last_c   = (CNT_W'(emitted_ff + 1'b1) == count_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      emitted_in  = emitted_ff;
      time_in     = time_ff;
      st_in       = st_ff;
      wt_in       = wt_ff;
      tt_in       = tt_ff;
      wsum_in     = wsum_ff;
      tsum_in     = tsum_ff;
      stall_c     = 1'b1;
      rd_en       = 1'b0;
      rd_addr     = scan_idx_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = count_ff[IDX_W-1:0];
      wr_data     = '0;
      sel_clear   = 1'b0;
      emit        = 1'b0;
      emit_zero   = 1'b0;

      unique case (state_ff)
         npps_pkg::ST_LOAD: begin
            stall_c = 1'b0;
            if (req_valid) begin
               if (count_ff < CNT_W'(MAX_JOBS)) begin
                  wr_en            = 1'b1;
                  wr_data.finished = 1'b0;
                  wr_data.tag      = req_job_tag;
                  wr_data.prio     = req_job_priority;
                  wr_data.arrival  = req_arrival_time;
                  wr_data.burst    = req_burst_time;
                  count_in         = CNT_W'(count_ff + 1'b1);
               end
               if (req_last_job) begin
                  time_in     = '0;
                  wsum_in     = '0;
                  tsum_in     = '0;
                  emitted_in  = '0;
                  scan_idx_in = '0;
                  sel_clear   = 1'b1;
                  state_in    = npps_pkg::ST_SCAN;
               end
            end
         end

         npps_pkg::ST_SCAN: begin
            if (scan_idx_ff < count_ff) begin
               rd_en       = 1'b1;
               scan_idx_in = CNT_W'(scan_idx_ff + 1'b1);
            end else if (!chk_valid_ff) begin
               state_in = npps_pkg::ST_DECIDE;
            end
         end

         npps_pkg::ST_DECIDE: begin
            if (pick.any_ready) begin
               st_in   = time_ff;
               wt_in   = time_ff - TIME_W'(pick.best.arrival);
               tt_in   = time_ff + TIME_W'(pick.best.burst) - TIME_W'(pick.best.arrival);
               time_in = time_ff + TIME_W'(pick.best.burst);
               // Write the chosen job back as finished.
               wr_en            = 1'b1;
               wr_addr          = best_idx;
               wr_data          = pick.best;
               wr_data.finished = 1'b1;
               state_in         = npps_pkg::ST_EMIT;
            end else if (pick.any_pending) begin
               time_in     = TIME_W'(pick.next_arrival);
               scan_idx_in = '0;
               sel_clear   = 1'b1;
               state_in    = npps_pkg::ST_SCAN;
            end else begin
               scan_idx_in = '0;
               state_in    = npps_pkg::ST_ZREAD;
            end
         end

         npps_pkg::ST_EMIT: begin
            if (!out_hold) begin
               emit        = 1'b1;
               wsum_in     = wsum_ff + SUM_W'(wt_ff);
               tsum_in     = tsum_ff + SUM_W'(tt_ff);
               emitted_in  = CNT_W'(emitted_ff + 1'b1);
               scan_idx_in = '0;
               sel_clear   = 1'b1;
               state_in    = npps_pkg::ST_SCAN;
            end
         end

         npps_pkg::ST_ZREAD: begin
            if (scan_idx_ff == count_ff) begin
               count_in = '0;
               state_in = npps_pkg::ST_LOAD;
            end else begin
               rd_en       = 1'b1;
               scan_idx_in = CNT_W'(scan_idx_ff + 1'b1);
               state_in    = npps_pkg::ST_ZCHECK;
            end
         end

         npps_pkg::ST_ZCHECK: begin
            if (rd_data.burst != '0) begin
               state_in = npps_pkg::ST_ZREAD;
            end else if (!out_hold) begin
               emit_zero  = 1'b1;
               emitted_in = CNT_W'(emitted_ff + 1'b1);
               state_in   = npps_pkg::ST_ZREAD;
            end
         end

         default: begin
            state_in = npps_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npps_pkg::ST_LOAD;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= (state_ff == npps_pkg::ST_SCAN) && rd_en;
         rsp_valid_ff <= emit || emit_zero || out_hold;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      emitted_ff  <= emitted_in;
      time_ff     <= time_in;
      st_ff       <= st_in;
      wt_ff       <= wt_in;
      tt_ff       <= tt_in;
      wsum_ff     <= wsum_in;
      tsum_ff     <= tsum_in;
      chk_idx_ff  <= scan_idx_ff[IDX_W-1:0];
      if (emit) begin
         rsp_tag_ff   <= pick.best.tag;
         rsp_start_ff <= st_ff;
         rsp_wait_ff  <= wt_ff;
         rsp_turn_ff  <= tt_ff;
         rsp_wsum_ff  <= wsum_in;
         rsp_tsum_ff  <= tsum_in;
         rsp_last_ff  <= last_c;
      end else if (emit_zero) begin
         rsp_tag_ff   <= rd_data.tag;
         rsp_start_ff <= '0;
         rsp_wait_ff  <= '0;
         rsp_turn_ff  <= '0;
         rsp_wsum_ff  <= wsum_ff;
         rsp_tsum_ff  <= tsum_ff;
         rsp_last_ff  <= last_c;
      end
   end

   assign req_stall           = stall_c;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_done_tag        = rsp_tag_ff;
   assign rsp_start_time      = rsp_start_ff;
   assign rsp_wait_time       = rsp_wait_ff;
   assign rsp_turnaround_time = rsp_turn_ff;
   assign rsp_wait_sum        = rsp_wsum_ff;
   assign rsp_turnaround_sum  = rsp_tsum_ff;
   assign rsp_last_result     = rsp_last_ff;

endmodule

FILE: src/npps_checker.sv
// Port-level checks for the nonpreemptive priority scheduler, bound to the top level.
`timescale 1ns / 1ps

module npps_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [npps_pkg::TAG_W-1:0]    req_job_tag,
   input logic [npps_pkg::PRIO_W-1:0]   req_job_priority,
   input logic [npps_pkg::ARR_W-1:0]    req_arrival_time,
   input logic [npps_pkg::BURST_W-1:0]  req_burst_time,
   input logic                          req_last_job,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [npps_pkg::TAG_W-1:0]    rsp_done_tag,
   input logic [npps_pkg::TIME_W-1:0]   rsp_start_time,
   input logic [npps_pkg::TIME_W-1:0]   rsp_wait_time,
   input logic [npps_pkg::TIME_W-1:0]   rsp_turnaround_time,
   input logic [npps_pkg::SUM_W-1:0]    rsp_wait_sum,
   input logic [npps_pkg::SUM_W-1:0]    rsp_turnaround_sum,
   input logic                          rsp_last_result
);

   // A refused result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_done_tag) &&
         $stable(rsp_wait_sum) && $stable(rsp_last_result))
      else $error("refused result changed");

   // The request that closes a job set starts the schedule, so no request follows at once.
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_job |=> req_stall)
      else $error("request taken right after the last job");

   // A job never waits longer than it takes to finish, nor longer than its start time.
   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_wait_time <= rsp_turnaround_time) &&
         (rsp_wait_time <= rsp_start_time))
      else $error("wait time exceeds turnaround or start time");

   // Every turnaround contains its wait, so the totals keep that order.
   a_sum_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wait_sum <= rsp_turnaround_sum)
      else $error("wait sum exceeds turnaround sum");

endmodule

bind nonpreemptive_priority_scheduler npps_checker u_npps_checker (.*);
